// ----- hdl/moving_obstacle_lateral_flag_unit_macros.svh -----
// Assertion macros shared by the moving-obstacle lateral flag checker.
// Depends on nothing; include this header by its bare file name.
`ifndef MOVING_OBSTACLE_LATERAL_FLAG_UNIT_MACROS_SVH
`define MOVING_OBSTACLE_LATERAL_FLAG_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MOLF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MOLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/molf_pkg.sv -----
// Package for the moving-obstacle lateral flag unit: widths, bus layout and
// configuration register indexes. Depends on nothing.
`default_nettype none

package molf_pkg;

    // Coordinate and counter widths.
    localparam int COORD_BITS = 16;
    localparam int COUNT_BITS = 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Stream bus layout.
    localparam int S_TDATA_BITS = 4 * COORD_BITS;
    localparam int M_TDATA_BITS = 8;

    // Configuration port layout.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int LIMIT_BITS     = 16;
    localparam int SETTING_BITS   = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MIN_Y_SPAN         = 3'd0,
        CFG_MAX_Y_SPAN         = 3'd1,
        CFG_MAX_X_WIDTH        = 3'd2,
        CFG_MIN_X_DISTANCE     = 3'd3,
        CFG_SAMPLES_PER_DELTA  = 3'd4,
        CFG_DELTAS_PER_VERDICT = 3'd5,
        CFG_MIN_DELTA          = 3'd6,
        CFG_MAX_DELTA          = 3'd7
    } cfg_index_t;

endpackage

`default_nettype wire

// ----- hdl/moving_obstacle_lateral_flag_unit.sv -----
// Top level of the moving-obstacle lateral flag unit.
// Depends on molf_pkg for widths and configuration register indexes.
//
// Usage: segments of a lidar obstacle message enter on the s_axis channel,
// one per transaction, with tlast on the last segment of the message. Each
// message end yields one result transaction on m_axis carrying moving_flag;
// other segments yield no result. The user must write limits and counts on
// the cfg channel (always ready) only while the block is idle; the block
// itself does not enforce this. A segment accepted into the input register is
// evaluated into the result register as it moves on, and its result stays
// valid there until taken. Throughput: one segment per cycle while no stall
// holds the input register. The evaluation path (abs differences, limit
// compares and counter updates) is combinational between the two registers.
// Stall: when the result register is full and not taken, a message-end segment
// waits in the input register and s_axis_tready drops; segments without tlast
// still pass through. Reset clears the kept y values, both counts and both
// valid flags, sets all_in_band and loads the configuration reset values.
`default_nettype none

module moving_obstacle_lateral_flag_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Segment input stream.
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // tdata from bit 0: first_x, first_y, last_x, last_y (signed Q8.8).
    input  wire logic [molf_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,
    input  wire logic                                  s_axis_tlast,
    // Result stream.
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // tdata from bit 0: moving_flag, then zero padding.
    output logic [molf_pkg::M_TDATA_BITS-1:0]          m_axis_tdata,
    // Configuration write channel.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [molf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [molf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int CB = molf_pkg::COORD_BITS;
    localparam int NB = molf_pkg::COUNT_BITS;
    localparam int LB = molf_pkg::LIMIT_BITS;
    localparam int SB = molf_pkg::SETTING_BITS;

    // Absolute difference of two signed coordinates, one bit wider.
    function automatic logic [CB:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic signed [CB:0] d;
        begin
            d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
            abs_diff = d[CB] ? (-d) : d;
        end
    endfunction

    // Magnitude of a signed coordinate, one bit wider.
    function automatic logic [CB:0] magnitude(input logic [CB-1:0] a);
        logic signed [CB:0] e;
        begin
            e = $signed({a[CB-1], a});
            magnitude = e[CB] ? (-e) : e;
        end
    endfunction

    // Configuration registers.
    logic [LB-1:0] min_y_span_reg;
    logic [LB-1:0] max_y_span_reg;
    logic [LB-1:0] max_x_width_reg;
    logic [LB-1:0] min_x_distance_reg;
    logic [SB-1:0] samples_per_delta_reg;
    logic [SB-1:0] deltas_per_verdict_reg;
    logic [LB-1:0] min_delta_reg;
    logic [LB-1:0] max_delta_reg;

    // Input register.
    logic                                  in_vld_reg;
    logic [molf_pkg::S_TDATA_BITS-1:0]     in_data_reg;
    logic                                  in_last_reg;

    // Tracking state.
    logic [CB-1:0] first_kept_y_reg;
    logic [CB-1:0] latest_kept_y_reg;
    logic [NB-1:0] kept_count_reg;
    logic [NB-1:0] delta_count_reg;
    logic          all_in_band_reg;

    logic [CB-1:0] first_kept_y_next;
    logic [CB-1:0] latest_kept_y_next;
    logic [NB-1:0] kept_count_next;
    logic [NB-1:0] delta_count_next;
    logic          all_in_band_next;
    logic          flag_next;

    // Result register.
    logic out_vld_reg;
    logic flag_reg;

    logic advance;
    logic in_take;

    // The item in the input register moves on unless it needs the result slot while that is full and not taken.
    assign advance       = in_vld_reg && (!in_last_reg || !out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(molf_pkg::M_TDATA_BITS-1){1'b0}}, flag_reg};

    // Configuration write transactions.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_y_span_reg         <= '0;
            max_y_span_reg         <= '1;
            max_x_width_reg        <= '1;
            min_x_distance_reg     <= '0;
            samples_per_delta_reg  <= SB'(2);
            deltas_per_verdict_reg <= SB'(4);
            min_delta_reg          <= '0;
            max_delta_reg          <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (molf_pkg::cfg_index_t'(cfg_index))
                molf_pkg::CFG_MIN_Y_SPAN:         min_y_span_reg <= cfg_data[LB-1:0];
                molf_pkg::CFG_MAX_Y_SPAN:         max_y_span_reg <= cfg_data[LB-1:0];
                molf_pkg::CFG_MAX_X_WIDTH:        max_x_width_reg <= cfg_data[LB-1:0];
                molf_pkg::CFG_MIN_X_DISTANCE:     min_x_distance_reg <= cfg_data[LB-1:0];
                molf_pkg::CFG_SAMPLES_PER_DELTA:  samples_per_delta_reg <= cfg_data[SB-1:0];
                molf_pkg::CFG_DELTAS_PER_VERDICT: deltas_per_verdict_reg <= cfg_data[SB-1:0];
                molf_pkg::CFG_MIN_DELTA:          min_delta_reg <= cfg_data[LB-1:0];
                molf_pkg::CFG_MAX_DELTA:          max_delta_reg <= cfg_data[LB-1:0];
                default:                          ;
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Segment filter, kept-set update, delta and verdict for the registered item.
    always_comb
    begin
        logic [CB-1:0] fx;
        logic [CB-1:0] fy;
        logic [CB-1:0] lx;
        logic [CB-1:0] ly;
        logic [CB:0]   y_span;
        logic [CB:0]   x_width;
        logic [CB:0]   delta;
        logic          keep;
        logic          form_delta;
        logic          verdict;
        logic [CB-1:0] first_k;
        logic [CB-1:0] latest_k;
        logic [NB-1:0] kept_k;

        fx = in_data_reg[0*CB +: CB];
        fy = in_data_reg[1*CB +: CB];
        lx = in_data_reg[2*CB +: CB];
        ly = in_data_reg[3*CB +: CB];

        y_span  = abs_diff(fy, ly);
        x_width = abs_diff(fx, lx);
        keep    = (y_span > {1'b0, min_y_span_reg}) && (y_span < {1'b0, max_y_span_reg})
                  && (x_width < {1'b0, max_x_width_reg})
                  && (magnitude(fx) > {1'b0, min_x_distance_reg})
                  && (magnitude(lx) > {1'b0, min_x_distance_reg});

        // Remember the first and latest kept y; the count saturates.
        first_k  = (keep && (kept_count_reg == '0)) ? fy : first_kept_y_reg;
        latest_k = keep ? fy : latest_kept_y_reg;
        kept_k   = (keep && (kept_count_reg != molf_pkg::COUNT_MAX))
                   ? kept_count_reg + NB'(1) : kept_count_reg;

        first_kept_y_next  = first_k;
        latest_kept_y_next = latest_k;
        kept_count_next    = kept_k;
        delta_count_next   = delta_count_reg;
        all_in_band_next   = all_in_band_reg;
        flag_next          = 1'b0;

        delta      = abs_diff(first_k, latest_k);
        form_delta = in_last_reg && (kept_k >= NB'(samples_per_delta_reg));

        // At message end, enough kept segments form one delta and clear the set.
        if (form_delta)
        begin
            if (!((delta > {1'b0, min_delta_reg}) && (delta < {1'b0, max_delta_reg})))
            begin
                all_in_band_next = 1'b0;
            end
            if (delta_count_reg != molf_pkg::COUNT_MAX)
            begin
                delta_count_next = delta_count_reg + NB'(1);
            end
            kept_count_next    = '0;
            first_kept_y_next  = '0;
            latest_kept_y_next = '0;
        end

        // Enough deltas give a verdict and restart the tally.
        verdict = in_last_reg && (delta_count_next >= NB'(deltas_per_verdict_reg));
        if (verdict)
        begin
            flag_next        = all_in_band_next && (delta_count_next != '0);
            delta_count_next = '0;
            all_in_band_next = 1'b1;
        end
    end

    // Tracking state update as each item is evaluated.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_kept_y_reg  <= '0;
            latest_kept_y_reg <= '0;
            kept_count_reg    <= '0;
            delta_count_reg   <= '0;
            all_in_band_reg   <= 1'b1;
        end
        else if (advance)
        begin
            first_kept_y_reg  <= first_kept_y_next;
            latest_kept_y_reg <= latest_kept_y_next;
            kept_count_reg    <= kept_count_next;
            delta_count_reg   <= delta_count_next;
            all_in_band_reg   <= all_in_band_next;
        end
    end

    // Result register valid flag: loaded by a message end, cleared when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            flag_reg <= flag_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/molf_checker.sv -----
// Port-level checker for the moving-obstacle lateral flag unit, bound to the top level.
// Depends on molf_pkg and the assertion macros header.
`default_nettype none
`include "moving_obstacle_lateral_flag_unit_macros.svh"

module molf_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_axis_tready,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [molf_pkg::M_TDATA_BITS-1:0]    m_axis_tdata
);

    // A stalled result transaction keeps its flag.
    `MOLF_ASSERT_NEXT(a_result_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Only the flag bit of a result may be set.
    `MOLF_ASSERT_NOW(a_padding_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[molf_pkg::M_TDATA_BITS-1:1] == '0, "result padding bits set")

    // The input side only stalls behind a full, stalled result slot.
    `MOLF_ASSERT_NOW(a_stall_cause, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

endmodule

bind moving_obstacle_lateral_flag_unit molf_checker u_molf_checker (.*);

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the moving-obstacle lateral flag unit.
// Depends on molf_pkg and moving_obstacle_lateral_flag_unit from the RTL.

module tb_top;
    import molf_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_ROUNDS  = 12;
    localparam int ROUND_ITEMS    = 30;

    // One segment as it travels on s_axis_tdata; first_x sits in the lowest bits.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] last_y;
        logic signed [COORD_BITS-1:0] last_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] first_x;
    } segment_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [S_TDATA_BITS-1:0]   s_axis_tdata;
    logic                      s_axis_tlast;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_axis_tdata;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // Shadow copy of the limits and settings held by the unit.
    logic [LIMIT_BITS-1:0]   lim_min_y_span;
    logic [LIMIT_BITS-1:0]   lim_max_y_span;
    logic [LIMIT_BITS-1:0]   lim_max_x_width;
    logic [LIMIT_BITS-1:0]   lim_min_x_dist;
    logic [SETTING_BITS-1:0] set_samples;
    logic [SETTING_BITS-1:0] set_deltas;
    logic [LIMIT_BITS-1:0]   lim_min_delta;
    logic [LIMIT_BITS-1:0]   lim_max_delta;

    // Shadow copy of the tracking state.
    logic signed [COORD_BITS-1:0] first_kept_y;
    logic signed [COORD_BITS-1:0] latest_kept_y;
    logic [COUNT_BITS-1:0]        kept_cnt;
    logic [COUNT_BITS-1:0]        delta_cnt;
    logic                         all_in_band;

    logic moving_flag_q[$];
    int   mismatch_count = 0;
    int   idle_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_active = 1'b0;
    event hold_start_ev;

    moving_obstacle_lateral_flag_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // Absolute difference of two signed coordinates, exact in 32 bits.
    function automatic int span_of(input logic signed [COORD_BITS-1:0] a,
                                   input logic signed [COORD_BITS-1:0] b);
        int ia;
        int ib;
        ia = a;
        ib = b;
        return (ia > ib) ? ia - ib : ib - ia;
    endfunction

    function automatic int magnitude(input logic signed [COORD_BITS-1:0] a);
        int ia;
        ia = a;
        return (ia < 0) ? -ia : ia;
    endfunction

    // Updates the tracking state for one segment and queues the flag at message end.
    function automatic void predict_segment(input segment_t seg, input logic msg_end);
        int   y_span;
        int   x_width;
        int   delta;
        logic flag;
        y_span  = span_of(seg.first_y, seg.last_y);
        x_width = span_of(seg.first_x, seg.last_x);
        if (y_span > lim_min_y_span && y_span < lim_max_y_span &&
            x_width < lim_max_x_width &&
            magnitude(seg.first_x) > lim_min_x_dist &&
            magnitude(seg.last_x) > lim_min_x_dist)
        begin
            if (kept_cnt == 0)
                first_kept_y = seg.first_y;
            latest_kept_y = seg.first_y;
            if (kept_cnt != COUNT_MAX)
                kept_cnt = kept_cnt + 1'b1;
        end
        if (!msg_end)
            return;
        // An overshoot of the sample setting still forms a delta.
        if (kept_cnt >= set_samples)
        begin
            delta = span_of(first_kept_y, latest_kept_y);
            if (!(delta > lim_min_delta && delta < lim_max_delta))
                all_in_band = 1'b0;
            if (delta_cnt != COUNT_MAX)
                delta_cnt = delta_cnt + 1'b1;
            kept_cnt      = '0;
            first_kept_y  = '0;
            latest_kept_y = '0;
        end
        flag = 1'b0;
        if (delta_cnt >= set_deltas)
        begin
            flag        = all_in_band && (delta_cnt != 0);
            delta_cnt   = '0;
            all_in_band = 1'b1;
        end
        moving_flag_q = {moving_flag_q, flag};
    endfunction

    // Tracks register writes and accepted segments, and checks each result transaction.
    always @(posedge clk)
    begin : monitor
        logic exp_flag;
        if (!rst_n)
        begin
            lim_min_y_span  = '0;
            lim_max_y_span  = '1;
            lim_max_x_width = '1;
            lim_min_x_dist  = '0;
            set_samples     = 8'd2;
            set_deltas      = 8'd4;
            lim_min_delta   = '0;
            lim_max_delta   = '1;
            first_kept_y    = '0;
            latest_kept_y   = '0;
            kept_cnt        = '0;
            delta_cnt       = '0;
            all_in_band     = 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_MIN_Y_SPAN:         lim_min_y_span  = cfg_data;
                    CFG_MAX_Y_SPAN:         lim_max_y_span  = cfg_data;
                    CFG_MAX_X_WIDTH:        lim_max_x_width = cfg_data;
                    CFG_MIN_X_DISTANCE:     lim_min_x_dist  = cfg_data;
                    CFG_SAMPLES_PER_DELTA:  set_samples     = cfg_data[SETTING_BITS-1:0];
                    CFG_DELTAS_PER_VERDICT: set_deltas      = cfg_data[SETTING_BITS-1:0];
                    CFG_MIN_DELTA:          lim_min_delta   = cfg_data;
                    CFG_MAX_DELTA:          lim_max_delta   = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_segment(segment_t'(s_axis_tdata), s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (moving_flag_q.size() == 0)
                begin
                    $error("moving_flag: result transaction with no segment pending (got %0d)",
                           m_axis_tdata[0]);
                    mismatch_count++;
                end
                else
                begin
                    exp_flag = moving_flag_q.pop_front();
                    if (m_axis_tdata[0] !== exp_flag)
                    begin
                        $error("moving_flag: expected %0d, actual %0d", exp_flag, m_axis_tdata[0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[M_TDATA_BITS-1:1] !== '0)
                    begin
                        $error("tdata padding: expected 0, actual %0h",
                               m_axis_tdata[M_TDATA_BITS-1:1]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Ends the run when no transaction of any kind completes for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold while the stall request runs.
    always @(negedge clk)
        m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);

    // Long receiver hold, counted here so the sender keeps offering meanwhile.
    always
    begin
        @(hold_start_ev);
        @(posedge clk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
    end

    function automatic segment_t seg_of(input int fx, input int fy, input int lx, input int ly);
        segment_t seg;
        seg.first_x = COORD_BITS'(fx);
        seg.first_y = COORD_BITS'(fy);
        seg.last_x  = COORD_BITS'(lx);
        seg.last_y  = COORD_BITS'(ly);
        return seg;
    endfunction

    // Offers one segment, with random idle cycles ahead of it, until it is accepted.
    task automatic send_segment(input segment_t seg, input logic msg_end);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = {$urandom, $urandom};
            @(negedge clk);
        end
        s_axis_tdata  = seg;
        s_axis_tlast  = msg_end;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Sends one message of segments that pass the default-style limits.
    task automatic send_message(input int n_segments, input int y_first, input int y_step);
        int y;
        for (int i = 0; i < n_segments; i++)
        begin
            y = y_first + i * y_step;
            send_segment(seg_of(1000, y, 1200, y + 500), i == n_segments - 1);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = CFG_DATA_BITS'(value);
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Stops offering segments and waits until every pending flag has been seen.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (moving_flag_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_extreme(input int lo, input int hi);
        case ($urandom_range(2))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // Reset settings, coordinate extremes and a first verdict.
    task automatic test_default_settings();
        send_message(2, 100, 300);
        send_segment(seg_of(-32768, -32768, 32767, 32767), 1'b0);
        send_segment(seg_of(32767, 32767, -32768, -32768), 1'b1);
        send_segment(seg_of(0, 0, 0, 0), 1'b1);
        send_message(2, -2000, 700);
        send_message(3, 5000, -400);
        send_message(2, 0, 0);
        drain_results();
    endtask

    // Each limit at its extreme, where nothing or everything passes.
    task automatic test_limit_extremes();
        write_reg(CFG_DELTAS_PER_VERDICT, 1);
        write_reg(CFG_SAMPLES_PER_DELTA, 2);
        write_reg(CFG_MIN_Y_SPAN, 65535);
        send_message(2, 0, 300);
        drain_results();
        write_reg(CFG_MIN_Y_SPAN, 0);
        write_reg(CFG_MAX_Y_SPAN, 0);
        send_message(2, 0, 300);
        drain_results();
        write_reg(CFG_MAX_Y_SPAN, 65535);
        write_reg(CFG_MAX_X_WIDTH, 0);
        send_message(2, 0, 300);
        drain_results();
        write_reg(CFG_MAX_X_WIDTH, 65535);
        write_reg(CFG_MIN_X_DISTANCE, 32768);
        send_message(2, 0, 300);
        drain_results();
        // Only the most negative x clears a distance of 32767.
        write_reg(CFG_MIN_X_DISTANCE, 32767);
        send_segment(seg_of(-32768, 0, -32768, 500), 1'b0);
        send_segment(seg_of(-32768, 700, -32768, 1200), 1'b1);
        drain_results();
        write_reg(CFG_MIN_X_DISTANCE, 0);
        write_reg(CFG_MIN_DELTA, 65535);
        write_reg(CFG_MAX_DELTA, 0);
        send_message(2, 0, 300);
        drain_results();
        write_reg(CFG_MIN_DELTA, 0);
        write_reg(CFG_MAX_DELTA, 65535);
        send_message(2, 0, 300);
        drain_results();
    endtask

    // Zero sample and zero verdict settings.
    task automatic test_zero_settings();
        write_reg(CFG_SAMPLES_PER_DELTA, 0);
        write_reg(CFG_DELTAS_PER_VERDICT, 0);
        send_segment(seg_of(0, 0, 0, 0), 1'b1);
        send_message(2, 0, 300);
        drain_results();
        write_reg(CFG_SAMPLES_PER_DELTA, 2);
        send_segment(seg_of(0, 0, 0, 0), 1'b1);
        send_message(2, 100, 250);
        drain_results();
    endtask

    // More kept segments than the sample setting, in one message and across two.
    task automatic test_overshoot();
        write_reg(CFG_SAMPLES_PER_DELTA, 2);
        write_reg(CFG_DELTAS_PER_VERDICT, 1);
        send_message(5, 0, 100);
        send_message(1, 0, 0);
        send_message(2, 300, 200);
        drain_results();
    endtask

    // Kept and delta counters driven to their full value.
    task automatic test_counter_saturation();
        write_reg(CFG_SAMPLES_PER_DELTA, 255);
        write_reg(CFG_DELTAS_PER_VERDICT, 1);
        send_message(260, -5000, 30);
        drain_results();
        write_reg(CFG_SAMPLES_PER_DELTA, 2);
        write_reg(CFG_DELTAS_PER_VERDICT, 255);
        repeat (255) send_message(2, 0, 300);
        drain_results();
    endtask

    // Result side held off while segments keep coming, so the input stalls.
    task automatic test_result_backpressure();
        write_reg(CFG_SAMPLES_PER_DELTA, 1);
        write_reg(CFG_DELTAS_PER_VERDICT, 2);
        -> hold_start_ev;
        for (int i = 0; i < 30; i++)
            send_message(2, i * 10, 300);
        drain_results();
    endtask

    // Random limits and messages over the four idling phases.
    task automatic test_random_traffic();
        int sent;
        int msg_len;
        int base_y;
        int mag_lo;
        int mag_hi;
        int span_lo;
        int span_hi;
        int s;
        int y0;
        int y1;
        int m1;
        int m2;
        int min_y;
        int min_d;
        bit noise;
        bit neg;
        segment_t seg;
        for (int r = 0; r < RANDOM_ROUNDS; r++)
        begin
            drain_results();
            case (r / 3)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            // Every third round takes limits at or near their extremes.
            if (r % 3 == 2)
            begin
                write_reg(CFG_MIN_Y_SPAN, pick_extreme(0, 65535));
                write_reg(CFG_MAX_Y_SPAN, pick_extreme(0, 65535));
                write_reg(CFG_MAX_X_WIDTH, pick_extreme(0, 65535));
                write_reg(CFG_MIN_X_DISTANCE, pick_extreme(0, 32768));
                write_reg(CFG_SAMPLES_PER_DELTA, pick_extreme(1, 255));
                write_reg(CFG_DELTAS_PER_VERDICT, pick_extreme(1, 255));
                write_reg(CFG_MIN_DELTA, pick_extreme(0, 65535));
                write_reg(CFG_MAX_DELTA, pick_extreme(0, 65535));
            end
            else
            begin
                min_y = $urandom_range(1500);
                min_d = $urandom_range(400);
                write_reg(CFG_MIN_Y_SPAN, min_y);
                write_reg(CFG_MAX_Y_SPAN, min_y + $urandom_range(6000, 2));
                write_reg(CFG_MAX_X_WIDTH, $urandom_range(65535, 200));
                write_reg(CFG_MIN_X_DISTANCE, $urandom_range(12000));
                write_reg(CFG_SAMPLES_PER_DELTA, $urandom_range(5, 1));
                write_reg(CFG_DELTAS_PER_VERDICT, $urandom_range(5, 1));
                write_reg(CFG_MIN_DELTA, min_d);
                write_reg(CFG_MAX_DELTA, min_d + $urandom_range(2500, 1));
            end
            sent = 0;
            while (sent < ROUND_ITEMS)
            begin
                msg_len = $urandom_range(6, 1);
                noise   = ($urandom_range(99) < 20);
                base_y  = int'($urandom_range(16000)) - 8000;
                for (int i = 0; i < msg_len; i++)
                begin
                    if (noise)
                        seg = {$urandom, $urandom};
                    else
                    begin
                        // Aim for a segment inside the current limits.
                        mag_lo = lim_min_x_dist + 1;
                        if (mag_lo > 32767)
                            mag_lo = 32767;
                        mag_hi = (mag_lo + 3000 > 32767) ? 32767 : mag_lo + 3000;
                        m1  = $urandom_range(mag_hi, mag_lo);
                        m2  = $urandom_range(mag_hi, mag_lo);
                        neg = 1'($urandom_range(1));
                        span_lo = lim_min_y_span + 1;
                        span_hi = int'(lim_max_y_span) - 1;
                        if (span_hi < span_lo)
                            span_hi = span_lo;
                        s  = $urandom_range(span_hi, span_lo);
                        y0 = base_y + int'($urandom_range(1200)) - 600;
                        y1 = y0 + s;
                        if (y1 > 32767)
                            y1 = y0 - s;
                        if (y1 < -32768)
                            y1 = -32768;
                        seg = seg_of(neg ? -m1 : m1, y0, neg ? -m2 : m2, y1);
                    end
                    send_segment(seg, i == msg_len - 1);
                    sent++;
                end
            end
        end
        drain_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_settings();
        test_limit_extremes();
        test_zero_settings();
        test_overshoot();
        test_counter_saturation();
        test_result_backpressure();
        test_random_traffic();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/molf_pkg.sv
hdl/moving_obstacle_lateral_flag_unit.sv
hdl/molf_checker.sv
sim/tb_top.sv
